/* design/lzbd_pkg.sv */
// Shared constants and types for the LZSS block decoder.
`default_nettype none

package lzbd_pkg;

   localparam int WIN_BYTES = 4096;
   localparam int WIN_AW    = $clog2(WIN_BYTES);
   localparam int MAX_COPY  = 18;
   localparam int CNT_W     = $clog2(MAX_COPY + 1);

   localparam logic [WIN_AW-1:0] FILL_LIMIT = WIN_AW'(4078);
   localparam logic [7:0]        FILL_BYTE  = 8'h20;

   // Configuration register values seen by the datapath.
   typedef struct packed {
      logic [23:0] expected_size;
      logic        signed_checksum;
   } cfg_type;

   // Window access for one cycle.
   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [WIN_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [WIN_AW-1:0] rd_addr;
   } win_req_type;

endpackage

`default_nettype wire

/* design/lzbd_csr.sv */
// APB configuration registers of the LZSS block decoder.
`default_nettype none

module lzbd_csr
   import lzbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   localparam logic REG_EXPECTED_SIZE = 1'b0;
   localparam logic REG_SIGNED_CKSUM  = 1'b1;

   logic [23:0] size_ff, size_in;
   logic        sgn_ff, sgn_in;
   logic        wr_acc;

   assign pready = 1'b1;
   assign wr_acc = psel && penable && pwrite;

   always_comb begin
      size_in = size_ff;
      sgn_in  = sgn_ff;
      if (wr_acc) begin
         case (paddr[2])
            REG_EXPECTED_SIZE: size_in = pwdata[23:0];
            REG_SIGNED_CKSUM:  sgn_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         sgn_ff  <= 1'b0;
      end else begin
         size_ff <= size_in;
         sgn_ff  <= sgn_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_EXPECTED_SIZE: prdata = {8'h00, size_ff};
         REG_SIGNED_CKSUM:  prdata = {31'h0, sgn_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.expected_size   = size_ff;
   assign cfg.signed_checksum = sgn_ff;

endmodule

`default_nettype wire

/* design/lzbd_window.sv */
// History window: 4 KiB RAM with fill tracking and read-after-write forwarding.
`default_nettype none

module lzbd_window
   import lzbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  win_req_type      req,
   output logic      [7:0]  rd_byte
);

   logic [7:0]        mem [WIN_BYTES];
   logic [7:0]        rdata_ff;
   logic [WIN_AW-1:0] addr_ff;
   logic              fwd_ff;
   logic [7:0]        fwd_data_ff;
   logic [WIN_AW:0]   fill_ff, fill_in, fill_base;
   logic [WIN_AW-1:0] rel;
   logic              written;

   // Writes run strictly in sequence from FILL_LIMIT, so a count of bytes
   // written since block start tells which entries still hold reset data.
   always_comb begin
      fill_base = req.clear ? '0 : fill_ff;
      if (req.wr_en && !fill_base[WIN_AW])
         fill_in = fill_base + 1'b1;
      else
         fill_in = fill_base;
   end

   always_ff @(posedge clock) begin
      if (reset)
         fill_ff <= '0;
      else
         fill_ff <= fill_in;
   end

   always_ff @(posedge clock) begin
      if (req.wr_en)
         mem[req.wr_addr] <= req.wr_data;
      if (req.rd_en)
         rdata_ff <= mem[req.rd_addr];
   end

   // Same-edge write to the entry being read: take the written byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (req.rd_en) begin
         fwd_ff <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         addr_ff     <= req.rd_addr;
         fwd_data_ff <= req.wr_data;
      end
   end

   assign rel     = addr_ff - FILL_LIMIT;
   assign written = fill_ff[WIN_AW] || (rel < fill_ff[WIN_AW-1:0]);

   always_comb begin
      if (fwd_ff)
         rd_byte = fwd_data_ff;
      else if (written)
         rd_byte = rdata_ff;
      else if (addr_ff < FILL_LIMIT)
         rd_byte = FILL_BYTE;
      else
         rd_byte = 8'h00;
   end

endmodule

`default_nettype wire

/* design/lzss_block_decoder_unit.sv */
// Top level of the LZSS block decoder: stream parser, match copy and result register.
`default_nettype none

// LZSS decoder with a 4096-byte history window. Compressed bytes enter on the
// req_ channel, one byte per request; decompressed bytes and block status
// leave on the rsp_ channel, with rsp_last marking the final result of each
// request. A match of N bytes (3..18) issues the first window read in the READ
// state, then moves one byte per cycle in the COPY state while the output
// register is free, paced by the single read port of the window RAM, whose
// read data is registered. A byte written in the same cycle that
// the next copy byte is read is forwarded. The window is not swept at block
// start: a count of bytes written since block_start marks which entries still
// read as their start-of-block value (space below 4078, zero above), so there
// is no clearing pass and a new block can start on the next request. The output
// register decouples the two sides; rsp_stall only delays progress. The user must
// write expected_size and signed_checksum over APB only while idle (not enforced).
module lzss_block_decoder_unit
   import lzbd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [7:0]  req_in_byte,
   input  wire logic               req_block_start,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [7:0]  rsp_out_byte,
   output logic                    rsp_is_status,
   output logic             [1:0]  rsp_status_code,
   output logic signed      [31:0] rsp_checksum,
   output logic                    rsp_last,
   // configuration
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic        [2:0]  paddr,
   input  wire logic        [31:0] pwdata,
   output logic             [31:0] prdata,
   output logic                    pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_COPY = 3'b100
   } ctl_state_type;

   typedef enum logic [4:0] {
      PH_FLAG     = 5'b00001,
      PH_TOKEN    = 5'b00010,
      PH_MATCH_HI = 5'b00100,
      PH_TRAILER  = 5'b01000,
      PH_DONE     = 5'b10000
   } phase_type;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_MISMATCH = 2'd1;
   localparam logic [1:0] STS_OVERRUN  = 2'd2;

   cfg_type           cfg;
   win_req_type       win_req;
   logic [7:0]        win_byte;

   ctl_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [WIN_AW-1:0] wi_ff, wi_in;
   logic [15:0]       flags_ff, flags_in;
   logic [7:0]        off_ff, off_in;
   logic [23:0]       left_ff, left_in;
   logic [31:0]       sum_ff, sum_in;
   logic [31:0]       tw_ff, tw_in;
   logic [2:0]        tc_ff, tc_in;
   logic [WIN_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // effective state once block_start is applied
   phase_type         e_phase;
   logic [WIN_AW-1:0] e_wi;
   logic [15:0]       e_flags;
   logic [7:0]        e_off;
   logic [23:0]       e_left;
   logic [31:0]       e_sum;
   logic [31:0]       e_tw;
   logic [2:0]        e_tc;
   logic [CNT_W-1:0]  count;
   logic [15:0]       flags_sh;

   // result register
   logic              rsp_valid_ff;
   logic              out_load;
   logic [7:0]        o_byte_ff, o_byte_in;
   logic              o_sts_ff, o_sts_in;
   logic [1:0]        o_code_ff, o_code_in;
   logic [31:0]       o_sum_ff, o_sum_in;
   logic              o_last_ff, o_last_in;

   logic              out_free;
   logic              req_acc;

   function automatic logic [31:0] add_byte(input logic [31:0] s, input logic [7:0] b,
                                            input logic sgn);
      logic [31:0] ext;
      ext = sgn ? {{24{b[7]}}, b} : {24'h0, b};
      return s + ext;
   endfunction

   // phase after a literal or a finished match
   function automatic phase_type next_phase(input logic [23:0] left,
                                            input logic [15:0] fl);
      phase_type ph;
      if (left == 24'd0)
         ph = PH_TRAILER;
      else if (fl[8])
         ph = PH_TOKEN;
      else
         ph = PH_FLAG;
      return ph;
   endfunction

   lzbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lzbd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .req     (win_req),
      .rd_byte (win_byte)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      wi_in     = wi_ff;
      flags_in  = flags_ff;
      off_in    = off_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      tw_in     = tw_ff;
      tc_in     = tc_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;

      win_req   = '0;
      out_load  = 1'b0;
      o_byte_in = 8'h00;
      o_sts_in  = 1'b0;
      o_code_in = STS_OK;
      o_sum_in  = sum_ff;
      o_last_in = 1'b0;

      // block restart
      if (req_block_start) begin
         e_phase = PH_FLAG;
         e_wi    = FILL_LIMIT;
         e_flags = '0;
         e_off   = '0;
         e_left  = cfg.expected_size;
         e_sum   = '0;
         e_tw    = '0;
         e_tc    = '0;
      end else begin
         e_phase = phase_ff;
         e_wi    = wi_ff;
         e_flags = flags_ff;
         e_off   = off_ff;
         e_left  = left_ff;
         e_sum   = sum_ff;
         e_tw    = tw_ff;
         e_tc    = tc_ff;
      end
      // nothing left to decode: remaining bytes are trailer
      if ((e_phase == PH_FLAG || e_phase == PH_TOKEN || e_phase == PH_MATCH_HI)
          && e_left == 24'd0)
         e_phase = PH_TRAILER;

      count    = CNT_W'(req_in_byte[3:0]) + CNT_W'(3);
      flags_sh = flags_ff >> 1;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               win_req.clear = req_block_start;
               phase_in = e_phase;
               wi_in    = e_wi;
               flags_in = e_flags;
               off_in   = e_off;
               left_in  = e_left;
               sum_in   = e_sum;
               tw_in    = e_tw;
               tc_in    = e_tc;
               case (e_phase)
                  PH_FLAG: begin
                     flags_in = {8'hFF, req_in_byte};
                     phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (e_flags[0]) begin
                        // literal
                        sum_in          = add_byte(e_sum, req_in_byte, cfg.signed_checksum);
                        win_req.wr_en   = 1'b1;
                        win_req.wr_addr = e_wi;
                        win_req.wr_data = req_in_byte;
                        wi_in           = e_wi + 1'b1;
                        left_in         = e_left - 1'b1;
                        flags_in        = e_flags >> 1;
                        phase_in        = next_phase(left_in, flags_in);
                        out_load        = 1'b1;
                        o_byte_in       = req_in_byte;
                        o_sum_in        = sum_in;
                        o_last_in       = 1'b1;
                     end else begin
                        off_in   = req_in_byte;
                        phase_in = PH_MATCH_HI;
                     end
                  end
                  PH_MATCH_HI: begin
                     if (24'(count) > e_left) begin
                        phase_in  = PH_DONE;
                        out_load  = 1'b1;
                        o_sts_in  = 1'b1;
                        o_code_in = STS_OVERRUN;
                        o_sum_in  = e_sum;
                        o_last_in = 1'b1;
                     end else begin
                        rd_ptr_in = e_wi - {req_in_byte[7:4], e_off};
                        cnt_in    = count;
                        state_in  = ST_READ;
                     end
                  end
                  PH_TRAILER: begin
                     tw_in = e_tw | ({24'h0, req_in_byte} << {e_tc[1:0], 3'b000});
                     tc_in = e_tc + 1'b1;
                     if (tc_in >= 3'd4) begin
                        phase_in  = PH_DONE;
                        out_load  = 1'b1;
                        o_sts_in  = 1'b1;
                        o_code_in = (tw_in == e_sum) ? STS_OK : STS_MISMATCH;
                        o_sum_in  = e_sum;
                        o_last_in = 1'b1;
                     end
                  end
                  default: ; // block ended: ignore until block_start
               endcase
            end
         end
         ST_READ: begin
            win_req.rd_en   = 1'b1;
            win_req.rd_addr = rd_ptr_ff;
            rd_ptr_in       = rd_ptr_ff + 1'b1;
            state_in        = ST_COPY;
         end
         ST_COPY: begin
            if (out_free) begin
               sum_in          = add_byte(sum_ff, win_byte, cfg.signed_checksum);
               win_req.wr_en   = 1'b1;
               win_req.wr_addr = wi_ff;
               win_req.wr_data = win_byte;
               wi_in           = wi_ff + 1'b1;
               left_in         = left_ff - 1'b1;
               cnt_in          = cnt_ff - 1'b1;
               out_load        = 1'b1;
               o_byte_in       = win_byte;
               o_sum_in        = sum_in;
               if (cnt_ff == CNT_W'(1)) begin
                  o_last_in = 1'b1;
                  flags_in  = flags_sh;
                  phase_in  = next_phase(left_in, flags_sh);
                  state_in  = ST_IDLE;
               end else begin
                  // next source byte; window forwards if it is this write
                  win_req.rd_en   = 1'b1;
                  win_req.rd_addr = rd_ptr_ff;
                  rd_ptr_in       = rd_ptr_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FLAG;
         wi_ff    <= FILL_LIMIT;
         flags_ff <= '0;
         off_ff   <= '0;
         left_ff  <= '0;
         sum_ff   <= '0;
         tw_ff    <= '0;
         tc_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wi_ff    <= wi_in;
         flags_ff <= flags_in;
         off_ff   <= off_in;
         left_ff  <= left_in;
         sum_ff   <= sum_in;
         tw_ff    <= tw_in;
         tc_ff    <= tc_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_byte_ff <= o_byte_in;
         o_sts_ff  <= o_sts_in;
         o_code_ff <= o_code_in;
         o_sum_ff  <= o_sum_in;
         o_last_ff <= o_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = o_byte_ff;
   assign rsp_is_status   = o_sts_ff;
   assign rsp_status_code = o_code_ff;
   assign rsp_checksum    = $signed(o_sum_ff);
   assign rsp_last        = o_last_ff;

`ifndef SYNTHESIS
   // a copy in flight always has bytes left to move
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (cnt_ff != '0))
      else $error("copy state with zero count");

   // the final copy byte returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && out_free && cnt_ff == CNT_W'(1)) |=> (state_ff == ST_IDLE))
      else $error("copy did not end after last byte");

   // a pending status result means the block has ended
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_sts_ff) |-> (phase_ff == PH_DONE))
      else $error("status result while block still open");

   // the final byte of a copy is flagged last
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && out_free && cnt_ff == CNT_W'(1)) |=> (rsp_valid && rsp_last))
      else $error("last copy byte not marked last");
`endif

endmodule

`default_nettype wire

/* sim/lzss_block_decoder_unit_test.sv */
// Self-checking testbench for the LZSS block decoder: directed and random streams.
`timescale 1ns / 1ps

module lzss_block_decoder_unit_test
   import lzbd_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
   localparam int HOLD_CYCLES    = 300;   // long response hold-off for the fill-up test
   localparam int SETTLE_CYCLES  = 40;    // covers the longest match copy and then some
   localparam int ITEM_TARGET    = 300;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [2:0] ADDR_EXPECTED_SIZE   = 3'd0;
   localparam logic [2:0] ADDR_SIGNED_CHECKSUM = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN = 2'd2;

   typedef enum logic [2:0] {
      ST_FLAG, ST_TOKEN, ST_MATCH_HI, ST_TRAILER, ST_DONE
   } parse_state_type;

   typedef enum logic [1:0] {
      RX_OPEN, RX_RANDOM, RX_EVERY_THIRD, RX_HEAVY
   } rx_mode_type;

   // One decoder output as the response channel carries it.
   typedef struct packed {
      logic [7:0]  data;
      logic        is_status;
      logic [1:0]  code;
      logic [31:0] csum;
      logic        last;
   } result_type;

   // ---------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_block_start;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_status;
   logic [1:0]  rsp_status_code;
   logic signed [31:0] rsp_checksum;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   lzss_block_decoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_status   (rsp_is_status),
      .rsp_status_code (rsp_status_code),
      .rsp_checksum    (rsp_checksum),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Decoder prediction: window, parser state and configuration copy
   // ---------------------------------------------------------------
   logic [7:0]      hist [WIN_BYTES];
   logic [11:0]     hist_wr;
   logic [15:0]     flag_reg;      // upper byte of ones marks when the flag byte is used up
   parse_state_type parse_st;
   logic [7:0]      offset_lo;
   logic [23:0]     bytes_due;
   logic [31:0]     run_sum;
   logic [31:0]     trailer_acc;
   logic [2:0]      trailer_cnt;
   logic [23:0]     cfg_size;
   logic            cfg_signed;

   result_type decoded_q[$];       // expected responses, oldest first
   int         decoded_items = 0;  // requests that were not simply dropped
   int         mismatches    = 0;
   int         burst_left    = 0;

   // Pressure hand-off: the test asks, the response side counts the hold itself.
   int holds_asked = 0;
   int holds_done  = 0;
   int hold_left   = 0;

   function automatic void restart_block();
      for (int i = 0; i < WIN_BYTES; i++)
         hist[i] = (i < FILL_LIMIT) ? FILL_BYTE : 8'h00;
      hist_wr     = FILL_LIMIT;
      flag_reg    = 16'h0;
      parse_st    = ST_FLAG;
      offset_lo   = 8'h0;
      bytes_due   = cfg_size;
      run_sum     = 32'h0;
      trailer_acc = 32'h0;
      trailer_cnt = 3'd0;
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input logic is_last);
      result_type r;
      run_sum = run_sum + (cfg_signed ? {{24{b[7]}}, b} : {24'h0, b});
      hist[hist_wr] = b;
      hist_wr   = hist_wr + 12'd1;
      bytes_due = bytes_due - 24'd1;
      r.data      = b;
      r.is_status = 1'b0;
      r.code      = STATUS_OK;
      r.csum      = run_sum;
      r.last      = is_last;
      decoded_q.insert(decoded_q.size(), r);
   endfunction

   function automatic void push_status(input logic [1:0] code);
      result_type r;
      r.data      = 8'h00;
      r.is_status = 1'b1;
      r.code      = code;
      r.csum      = run_sum;
      r.last      = 1'b1;
      decoded_q.insert(decoded_q.size(), r);
      parse_st = ST_DONE;
   endfunction

   function automatic void next_token();
      flag_reg = flag_reg >> 1;
      if (bytes_due == 0)
         parse_st = ST_TRAILER;
      else if (!flag_reg[8])
         parse_st = ST_FLAG;
      else
         parse_st = ST_TOKEN;
   endfunction

   // Advances the prediction by one accepted request and queues its responses.
   function automatic void decode_request(input logic [7:0] b, input logic start);
      logic [11:0] pos;
      logic [11:0] src;
      int          count;
      if (start)
         restart_block();
      if (parse_st != ST_DONE)
         decoded_items++;
      // nothing left to decode: flag and token bytes are read as trailer
      if (parse_st < ST_TRAILER && bytes_due == 0)
         parse_st = ST_TRAILER;
      case (parse_st)
         ST_FLAG: begin
            flag_reg = {8'hFF, b};
            parse_st = ST_TOKEN;
         end
         ST_TOKEN: begin
            if (flag_reg[0]) begin
               emit_byte(b, 1'b1);
               next_token();
            end else begin
               offset_lo = b;
               parse_st  = ST_MATCH_HI;
            end
         end
         ST_MATCH_HI: begin
            pos   = {b[7:4], offset_lo};
            count = int'(b[3:0]) + 3;
            if (count > bytes_due) begin
               push_status(STATUS_OVERRUN);
            end else begin
               // byte by byte, so an overlapping copy repeats what it just wrote
               src = hist_wr - pos;
               for (int k = 0; k < count; k++)
                  emit_byte(hist[src + 12'(k)], k == count - 1);
               next_token();
            end
         end
         ST_TRAILER: begin
            trailer_acc = trailer_acc | ({24'h0, b} << (8 * trailer_cnt[1:0]));
            trailer_cnt = trailer_cnt + 3'd1;
            if (trailer_cnt >= 3'd4)
               push_status((trailer_acc == run_sum) ? STATUS_OK : STATUS_BAD_SUM);
         end
         default: ;  // block ended: dropped until the next block start
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Response side: stall pattern with an occasional long hold-off
   // ---------------------------------------------------------------
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          rx_tick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(3, 0));
            rx_left <= $urandom_range(80, 10);
         end else begin
            rx_left <= rx_left - 1;
         end
         rx_tick <= rx_tick + 1;
         case (rx_mode)
            RX_OPEN:        rsp_stall <= 1'b0;
            RX_RANDOM:      rsp_stall <= ($urandom_range(3, 0) == 0);
            RX_EVERY_THIRD: rsp_stall <= (rx_tick % 3 == 0);
            default:        rsp_stall <= ($urandom_range(9, 0) < 7);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Response check: every accepted response against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected response byte %h status %b code %0d sum %h last %b",
                        $time, rsp_out_byte, rsp_is_status, rsp_status_code,
                        rsp_checksum, rsp_last);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.data || rsp_is_status !== want.is_status ||
                rsp_status_code !== want.code || rsp_checksum !== want.csum ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: expected byte %h status %b code %0d sum %h last %b",
                           $time, want.data, want.is_status, want.code, want.csum,
                           want.last);
                  $display("%0t:      got byte %h status %b code %0d sum %h last %b",
                           $time, rsp_out_byte, rsp_is_status, rsp_status_code,
                           rsp_checksum, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog: a long stretch with no handshake means the block hung.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------

   // Offers one request and holds it until taken; then either keeps the burst
   // going (valid stays high for the caller's next request) or idles a while.
   task automatic send_request(input logic [7:0] b, input logic start);
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_block_start <= start;
      do @(posedge clock); while (req_stall);
      decode_request(b, start);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(8, 0);
      end
   endtask

   // Waits until the block has nothing left to say, then a bit longer.
   task automatic drain();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write then read-back of one register; only while the block is idle.
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] mask;
      mask = (addr == ADDR_EXPECTED_SIZE) ? 32'h00FF_FFFF : 32'h0000_0001;
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_EXPECTED_SIZE)
         cfg_size = value[23:0];
      else
         cfg_signed = value[0];
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (value & mask)) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: register %0d read %h, expected %h", $time, addr,
                     prdata & mask, value & mask);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Four little-endian checksum bytes; a block of size zero starts on the first.
   task automatic send_sum_trailer(input logic start, input bit corrupt);
      logic [31:0] word;
      word = start ? 32'h0 : run_sum;
      if (corrupt)
         word = word ^ (32'h1 << $urandom_range(31, 0));
      for (int i = 0; i < 4; i++)
         send_request(word[8*i +: 8], start && i == 0);
   endtask

   // One block with random content, shaped from the predicted parser state so
   // that it decodes deep. cut_at > 0 stops after that many requests (the next
   // block start then cuts the block short).
   task automatic send_block(input int cut_at, input bit bad_trailer, input int overrun_pct);
      int          sent;
      bit          first;
      logic [23:0] rem;
      logic [7:0]  b;
      int          top;
      sent  = 0;
      first = 1'b1;
      do begin
         if (cut_at != 0 && sent == cut_at)
            break;
         rem = first ? cfg_size : bytes_due;
         if (first ? (cfg_size == 0) : (parse_st == ST_TRAILER)) begin
            send_sum_trailer(first, bad_trailer);
            break;
         end
         case (first ? ST_FLAG : parse_st)
            ST_FLAG: b = (rem < 3) ? 8'hFF : 8'($urandom);
            ST_MATCH_HI: begin
               top = (rem < 18) ? int'(rem) - 3 : 15;
               if (top >= 0 && $urandom_range(99, 0) >= overrun_pct)
                  b = {4'($urandom), 4'($urandom_range(top, 0))};
               else
                  b = 8'($urandom);
            end
            default: b = 8'($urandom);
         endcase
         send_request(b, first);
         first = 1'b0;
         sent++;
      end while (parse_st != ST_DONE);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Out of reset nothing is left to decode, so bytes go straight to the trailer.
   task automatic test_after_reset();
      send_sum_trailer(1'b0, 1'b1);
   endtask

   // Literals at the byte extremes, an overlapping 18-byte run off the last
   // literal, and a 3-byte copy from the space-filled part of the window.
   task automatic test_literal_and_match();
      drain();
      write_reg(ADDR_EXPECTED_SIZE, 32'd25);
      write_reg(ADDR_SIGNED_CHECKSUM, 32'd1);
      send_request(8'h0F, 1'b1);  // four literals, then two matches
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(8'h01, 1'b0);  // distance 1
      send_request(8'h0F, 1'b0);  // longest copy
      send_request(8'hFF, 1'b0);  // distance 4095
      send_request(8'hF0, 1'b0);  // shortest copy
      send_sum_trailer(1'b0, 1'b0);
   endtask

   // A match longer than what is left ends the block; later bytes are dropped.
   task automatic test_overrun();
      drain();
      write_reg(ADDR_EXPECTED_SIZE, 32'd2);
      write_reg(ADDR_SIGNED_CHECKSUM, 32'd0);
      send_request(8'h00, 1'b1);
      send_request(8'h34, 1'b0);
      send_request(8'h50, 1'b0);
      send_request(8'hA5, 1'b0);
   endtask

   task automatic test_empty_block();
      drain();
      write_reg(ADDR_EXPECTED_SIZE, 32'd0);
      send_sum_trailer(1'b1, 1'b0);
   endtask

   // Largest size: start a block and cut it short with the next block start.
   task automatic test_max_size();
      drain();
      write_reg(ADDR_EXPECTED_SIZE, 32'h00FF_FFFF);
      send_request(8'hFF, 1'b1);
      send_request(8'h55, 1'b0);
      send_request(8'hAA, 1'b0);
   endtask

   // Response side holds off for a long stretch while requests keep coming,
   // so the block backs up and stalls its input.
   task automatic test_backpressure();
      drain();
      write_reg(ADDR_EXPECTED_SIZE, 32'd64);
      write_reg(ADDR_SIGNED_CHECKSUM, 32'd1);
      holds_asked++;
      send_block(0, 1'b0, 0);
   endtask

   task automatic test_random_blocks();
      int          goal;
      int          blocks;
      int          pick;
      int          kind;
      logic [23:0] size;
      goal   = decoded_items + ITEM_TARGET;
      blocks = 0;
      while (decoded_items < goal) begin
         if (blocks % 4 == 0) begin
            drain();
            pick = $urandom_range(19, 0);
            if (pick == 0)
               size = 24'd0;
            else if (pick == 1)
               size = 24'hFF_FFFF;
            else if (pick <= 3)
               size = 24'($urandom_range(250, 100));
            else
               size = 24'($urandom_range(40, 1));
            write_reg(ADDR_EXPECTED_SIZE, {8'h0, size});
            write_reg(ADDR_SIGNED_CHECKSUM, $urandom_range(1, 0));
         end
         kind = $urandom_range(9, 0);
         send_block((kind == 0 || cfg_size > 24'd1000) ? $urandom_range(12, 1) : 0,
                    kind == 1 || kind == 2, (kind == 3) ? 50 : 3);
         // stray bytes after a finished block
         if (kind >= 8 && parse_st == ST_DONE)
            repeat ($urandom_range(3, 1)) send_request(8'($urandom), 1'b0);
         blocks++;
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_in_byte     <= 8'h00;
      req_block_start <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= 3'd0;
      pwdata          <= 32'h0;
      cfg_size   = 24'd0;
      cfg_signed = 1'b0;
      restart_block();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_literal_and_match();
      test_overrun();
      test_empty_block();
      test_max_size();
      test_backpressure();
      test_random_blocks();

      drain();
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
design/lzbd_pkg.sv
design/lzbd_csr.sv
design/lzbd_window.sv
design/lzss_block_decoder_unit.sv
sim/lzss_block_decoder_unit_test.sv
